### rtl/llmt_pkg.sv
package llmt_pkg;

   // Field widths fixed by the interface.
   localparam int EXP_W     = 6;
   localparam int RESIDUE_W = 63;

   // Lucas-Lehmer constants: seed value and the offset subtracted each step.
   localparam int LL_SEED   = 4;
   localparam int LL_OFFSET = 2;

   // The only even prime. It is answered directly without running the loop.
   localparam logic [EXP_W-1:0] EXP_TWO = 6'd2;

   // Bit n is set when n is prime, for n from 0 to 63.
   localparam logic [63:0] PRIME_MAP = 64'h2820_8A20_A08A_28AC;

   // Control from the sequencer to the datapath. Each flag selects one operation.
   typedef struct packed {
      logic load;       // capture a new exponent
      logic load_run;   // seed the residue with four instead of zero
      logic mul_ll;     // product of low half with low half
      logic mul_lh;     // product of low half with high half
      logic mul_hh;     // product of high half with high half
      logic acc_set;    // accumulator takes the registered product
      logic acc_mid;    // accumulator adds twice the cross product
      logic acc_top;    // accumulator adds the high square
      logic fold;       // fold the bits above the exponent onto the low bits
      logic reduce;     // conditional subtract of the modulus
      logic finish;     // subtract two modulo the Mersenne number
   } ctl_type;

   typedef struct packed {
      logic res_zero;   // residue register holds zero
   } status_type;

   function automatic logic is_prime_exp(input logic [EXP_W-1:0] n);
      return PRIME_MAP[n];
   endfunction

endpackage

### rtl/llmt_if.sv
interface llmt_req_if;
   logic                            valid;
   logic                            ready;
   logic [llmt_pkg::EXP_W-1:0]      exponent;

   modport source (output valid, output exponent, input ready);
   modport sink   (input valid, input exponent, output ready);
endinterface

interface llmt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            mersenne_is_prime;
   logic                            exponent_is_prime;
   logic [llmt_pkg::RESIDUE_W-1:0]  final_residue;

   modport source (output valid, output mersenne_is_prime, output exponent_is_prime,
                   output final_residue, input ready);
   modport sink   (input valid, input mersenne_is_prime, input exponent_is_prime,
                   input final_residue, output ready);
endinterface

### rtl/llmt_datapath.sv
// Shared squaring unit: one half-width multiplier, a wide accumulator and
// the fold-and-reduce logic for arithmetic modulo 2^p - 1.
module llmt_datapath #(
   parameter int RES_W = 63
) (
   input  logic                         clock,
   input  logic [llmt_pkg::EXP_W-1:0]   exponent,
   input  llmt_pkg::ctl_type            ctl,
   output llmt_pkg::status_type         status,
   output logic [RES_W-1:0]             residue
);

   localparam int LO_W   = (RES_W + 1) / 2;
   localparam int HI_W   = RES_W - LO_W;
   localparam int PROD_W = 2 * LO_W;
   localparam int ACC_W  = 2 * RES_W;
   localparam int R_W    = RES_W + 1;

   logic [llmt_pkg::EXP_W-1:0] exp_ff, exp_in;
   logic [RES_W-1:0]           mask_ff, mask_in;
   logic [RES_W-1:0]           residue_ff, residue_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [R_W-1:0]             r_ff, r_in;

   logic [LO_W-1:0]            lo_part;
   logic [HI_W-1:0]            hi_part;
   logic [LO_W-1:0]            hi_ext;
   logic [LO_W-1:0]            mul_a;
   logic [LO_W-1:0]            mul_b;
   logic [R_W-1:0]             mask_ext;

   assign lo_part  = residue_ff[LO_W-1:0];
   assign hi_part  = residue_ff[RES_W-1:LO_W];
   assign hi_ext   = LO_W'(hi_part);
   assign mul_a    = ctl.mul_hh ? hi_ext : lo_part;
   assign mul_b    = ctl.mul_ll ? lo_part : hi_ext;
   assign mask_ext = R_W'(mask_ff);

   always_comb begin
      exp_in     = exp_ff;
      mask_in    = mask_ff;
      residue_in = residue_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      r_in       = r_ff;

      if (ctl.load) begin
         exp_in     = exponent;
         mask_in    = ~({RES_W{1'b1}} << exponent);
         residue_in = ctl.load_run ? RES_W'(llmt_pkg::LL_SEED) : '0;
      end

      if (ctl.mul_ll || ctl.mul_lh || ctl.mul_hh) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      // The square is (hi*2^LO_W + lo)^2 = lo^2 + 2*lo*hi*2^LO_W + hi^2*2^(2*LO_W).
      if (ctl.acc_set) begin
         acc_in = ACC_W'(prod_ff);
      end else if (ctl.acc_mid) begin
         acc_in = acc_ff + (ACC_W'(prod_ff) << (LO_W + 1));
      end else if (ctl.acc_top) begin
         acc_in = acc_ff + (ACC_W'(prod_ff) << PROD_W);
      end

      // Since 2^p is one modulo 2^p - 1, the bits above p add onto the low bits.
      if (ctl.fold) begin
         r_in = R_W'(acc_ff & ACC_W'(mask_ff)) + R_W'(acc_ff >> exp_ff);
      end else if (ctl.reduce) begin
         r_in = (r_ff >= mask_ext) ? (r_ff - mask_ext) : r_ff;
      end

      if (ctl.finish) begin
         if (r_ff >= R_W'(llmt_pkg::LL_OFFSET)) begin
            residue_in = RES_W'(r_ff - R_W'(llmt_pkg::LL_OFFSET));
         end else begin
            residue_in = RES_W'(r_ff + mask_ext - R_W'(llmt_pkg::LL_OFFSET));
         end
      end
   end

   always_ff @(posedge clock) begin
      exp_ff     <= exp_in;
      mask_ff    <= mask_in;
      residue_ff <= residue_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      r_ff       <= r_in;
   end

   assign residue         = residue_ff;
   assign status.res_zero = (residue_ff == '0);

endmodule

### rtl/llmt_seq.sv
// Sequencer: takes one request, steps the shared squaring unit through
// the Lucas-Lehmer iterations and holds the response until it is taken.
module llmt_seq #(
   parameter int MAX_EXPONENT = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [llmt_pkg::EXP_W-1:0]   req_exponent,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         mersenne_flag,
   output logic                         exponent_flag,
   output llmt_pkg::ctl_type            ctl,
   input  llmt_pkg::status_type         status
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_MUL0 = 10'b00_0000_0010,
      S_MUL1 = 10'b00_0000_0100,
      S_MUL2 = 10'b00_0000_1000,
      S_ACC  = 10'b00_0001_0000,
      S_FOLD = 10'b00_0010_0000,
      S_RED1 = 10'b00_0100_0000,
      S_RED2 = 10'b00_1000_0000,
      S_SUB  = 10'b01_0000_0000,
      S_DONE = 10'b10_0000_0000
   } state_type;

   localparam logic [llmt_pkg::EXP_W-1:0] MAX_EXP_L = llmt_pkg::EXP_W'(MAX_EXPONENT);
   localparam logic [llmt_pkg::EXP_W-1:0] STEP_SKIP = llmt_pkg::EXP_W'(llmt_pkg::LL_OFFSET);

   state_type                  state_ff, state_in;
   logic [llmt_pkg::EXP_W-1:0] count_ff, count_in;
   logic                       exp_prime_ff, exp_prime_in;
   logic                       two_ff, two_in;
   logic                       run_ff, run_in;

   logic                       accept;
   logic                       prime_now;
   logic                       run_now;

   // No request is taken while reset is held.
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = (state_ff == S_DONE);
   assign accept    = req_valid && req_ready;
   assign prime_now = llmt_pkg::is_prime_exp(req_exponent);
   assign run_now   = prime_now && (req_exponent != llmt_pkg::EXP_TWO) &&
                      (req_exponent <= MAX_EXP_L);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      exp_prime_in = exp_prime_ff;
      two_in       = two_ff;
      run_in       = run_ff;
      ctl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.load     = 1'b1;
               ctl.load_run = run_now;
               exp_prime_in = prime_now;
               two_in       = prime_now && (req_exponent == llmt_pkg::EXP_TWO);
               run_in       = run_now;
               count_in     = req_exponent - STEP_SKIP;
               state_in     = run_now ? S_MUL0 : S_DONE;
            end
         end
         S_MUL0: begin
            ctl.mul_ll = 1'b1;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            ctl.mul_lh  = 1'b1;
            ctl.acc_set = 1'b1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            ctl.mul_hh  = 1'b1;
            ctl.acc_mid = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            ctl.acc_top = 1'b1;
            state_in    = S_FOLD;
         end
         S_FOLD: begin
            ctl.fold = 1'b1;
            state_in = S_RED1;
         end
         S_RED1: begin
            ctl.reduce = 1'b1;
            state_in   = S_RED2;
         end
         S_RED2: begin
            ctl.reduce = 1'b1;
            state_in   = S_SUB;
         end
         S_SUB: begin
            ctl.finish = 1'b1;
            count_in   = count_ff - 1'b1;
            state_in   = (count_ff == llmt_pkg::EXP_W'(1)) ? S_DONE : S_MUL0;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_prime_ff <= exp_prime_in;
      two_ff       <= two_in;
      run_ff       <= run_in;
   end

   assign exponent_flag = exp_prime_ff;
   assign mersenne_flag = two_ff || (run_ff && status.res_zero);

endmodule

### rtl/lucas_lehmer_mersenne_test.sv
// Lucas-Lehmer test of the Mersenne number 2^p - 1 for an exponent p below 64.
// The request channel carries the exponent. The response channel returns
// whether 2^p - 1 is prime, whether p itself is prime, and the final residue.
// Exponents that are not prime, or prime but above MAX_EXPONENT, answer with
// a residue of zero; an exponent of two answers prime without iterating.
// Each request not dropped by reset yields exactly one response.
// The response is valid in the cycle after the request is accepted when
// no iterations are needed, and after p-2 iterations otherwise. Each
// iteration makes three passes through the single half-width multiplier
// (low-low, low-high, high-high) with accumulation, one fold of the upper
// product bits, two conditional subtracts of the modulus and the
// subtraction of two.
// One request is in flight at a time: request ready is high only while the
// block is idle, and the next request is taken in the cycle after the
// response handshake. While the receiver stalls, the response and all its
// fields are held unchanged and no new request is accepted.
// Reset is synchronous and returns the sequencer to idle; any request in
// progress is dropped and no response is produced for it.
module lucas_lehmer_mersenne_test #(
   parameter int MAX_EXPONENT = 63
) (
   input  logic         clock,
   input  logic         reset,
   llmt_req_if.sink     req_bus,
   llmt_rsp_if.source   rsp_bus
);

   // The residue never needs more bits than the largest exponent allowed.
   localparam int RES_W = MAX_EXPONENT;

   llmt_pkg::ctl_type    ctl;
   llmt_pkg::status_type status;
   logic [RES_W-1:0]     residue;

   // Sequencer: owns the handshakes, the iteration count and the flags.
   llmt_seq #(
      .MAX_EXPONENT (MAX_EXPONENT)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_exponent  (req_bus.exponent),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .mersenne_flag (rsp_bus.mersenne_is_prime),
      .exponent_flag (rsp_bus.exponent_is_prime),
      .ctl           (ctl),
      .status        (status)
   );

   // Datapath: the shared multiplier, accumulator and modular reduction.
   llmt_datapath #(
      .RES_W (RES_W)
   ) u_datapath (
      .clock    (clock),
      .exponent (req_bus.exponent),
      .ctl      (ctl),
      .status   (status),
      .residue  (residue)
   );

   // The residue register holds its value from the last step until the next
   // request is loaded, so the response payload is stable while stalled.
   assign rsp_bus.final_residue = llmt_pkg::RESIDUE_W'(residue);

endmodule

### rtl/llmt_checker.sv
module llmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             mersenne_is_prime,
   input logic                             exponent_is_prime,
   input logic [llmt_pkg::RESIDUE_W-1:0]   final_residue
);

   // A response waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // Only one request is in flight: never ready while a response is shown.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // An accepted request makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken without a response in between");

   // A Mersenne prime needs a prime exponent.
   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!mersenne_is_prime || exponent_is_prime))
      else $error("Mersenne prime reported for a composite exponent");

   // No iterations run for a composite exponent, so its residue is zero.
   a_composite_residue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !exponent_is_prime |-> (final_residue == '0))
      else $error("nonzero residue for a composite exponent");

endmodule

bind lucas_lehmer_mersenne_test llmt_checker u_llmt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .mersenne_is_prime (rsp_bus.mersenne_is_prime),
   .exponent_is_prime (rsp_bus.exponent_is_prime),
   .final_residue     (rsp_bus.final_residue)
);
